### hdl/nlis_pkg.sv
// Shared types and constants of the link impairment scheduler.
package nlis_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOSS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JITTER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REORDER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DUP      = 3'd5;
	localparam int CFG_DATA_W = 64;

	// Result kinds.
	localparam logic [1:0] KIND_QUEUED   = 2'd0;
	localparam logic [1:0] KIND_LOST     = 2'd1;
	localparam logic [1:0] KIND_FULL     = 2'd2;
	localparam logic [1:0] KIND_RELEASED = 2'd3;

	// Stream widths.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 144;

	// Generator constants.
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

	// Delay scaling: ticks = floor(floor(3*D / 2^25) / 50), the divide by 50
	// done as a multiply by a rounded-up reciprocal, exact for 19-bit values.
	localparam int          DIV_SHIFT = 26;
	localparam logic [20:0] DIV_RECIP = 21'd1342178;
	localparam int          DT_W      = 14;
	localparam logic [15:0] PULL_LIMIT = 16'd16384;

	// Most releases per tick item.
	localparam int MAX_RELEASE = 32;
	localparam int CNT_W       = 6;

	// Datapath operations.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_MIX_START,
		OP_MUL_P0,
		OP_MUL_P1,
		OP_MUL_P2,
		OP_MIX_MID,
		OP_MIX_END,
		OP_SAVE_A,
		OP_DELAY_MUL,
		OP_DELAY_SUM,
		OP_DELAY_DIV,
		OP_TARGET,
		OP_PULL,
		OP_ENQ_PRI,
		OP_ENQ_DUP,
		OP_EMIT_SEND,
		OP_EMIT_LOST,
		OP_TICK_SET,
		OP_SCAN_INIT,
		OP_SCAN_STEP,
		OP_TAKE,
		OP_EMIT_REL
	} nlis_op_t;

	typedef struct packed {
		nlis_op_t op;
		logic     last;
	} nlis_cmd_t;

	typedef struct packed {
		logic out_free;
		logic lost_hit;
		logic pull_hit;
		logic dup_hit;
		logic placed;
		logic loss_nz;
		logic mean_nz;
		logic win_nz;
		logic dup_nz;
		logic scan_end;
		logic found;
	} nlis_status_t;

endpackage

### hdl/network_link_impairment_scheduler_core.sv
// Top level of the link impairment scheduler.
//
// Input stream: s_axis_tuser is the mode (0 send a packet, 1 advance the tick);
// s_axis_tdata carries peer, channel, packet handle and tick value. Every send
// transfer yields one result; a tick transfer yields one result per released
// packet, up to 32, the last one marked by m_axis_tlast, or none at all.
// Configuration writes through cfg_we/cfg_index/cfg_data while the block idles;
// writing the seed also reloads the generator.
// Each random draw runs through the mixer states S_ADD, S_P0 to S_P2, S_MID,
// S_Q0 to S_Q2 and S_END on the shared 32x32 multiplier; S_DEC acts on it.
// A send makes up to five draws, runs the delay arithmetic (S_DMUL, S_DSUM,
// S_DDIV) when a delay is drawn, and takes a step each for a pull and for a
// duplicate copy. A tick item sets the tick, scans the whole queue for each
// release (sending the previous release first, if any) and ends with a closing
// scan, left out after the 32nd release. One item is worked on at a time.
// Reset clears the queue, counters, current tick, configuration and generator.
// If the receiver stalls, the finished result waits in the output register and
// the controller holds before the next emit; no result is lost.
module network_link_impairment_scheduler_core #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nlis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nlis_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// peer[15:0], channel[23:16], packet_handle[39:24], tick_value[71:40]
	input  logic [nlis_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// duplicated[0], out_peer[16:1], out_channel[24:17], out_handle[40:25],
	// due_tick[72:41], lost_count[104:73], dup_count[136:105], zeros above
	output logic [nlis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic [1:0]                      m_axis_tuser,
	// last_of_run
	output logic                            m_axis_tlast
);
	import nlis_pkg::*;

	nlis_cmd_t    cmd;
	nlis_status_t status;
	logic         in_accept;

	nlis_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.in_mode       (s_axis_tuser),
		.s_axis_tready (s_axis_tready),
		.in_accept     (in_accept),
		.status        (status),
		.cmd           (cmd)
	);

	nlis_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_accept     (in_accept),
		.in_data       (s_axis_tdata),
		.cmd           (cmd),
		.status        (status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### hdl/nlis_dpath.sv
// Datapath: configuration, generator, delay arithmetic, slot queue and output register.
module nlis_dpath #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nlis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nlis_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_accept,
	input  logic [nlis_pkg::IN_DATA_W-1:0]  in_data,
	input  nlis_pkg::nlis_cmd_t             cmd,
	output nlis_pkg::nlis_status_t          status,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [nlis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]                      m_axis_tuser,
	output logic                            m_axis_tlast
);
	import nlis_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Configuration registers.
	logic [16:0] loss_thr_q;
	logic [23:0] mean_q;
	logic [23:0] jitter_q;
	logic [15:0] window_q;
	logic [16:0] dup_thr_q;

	// Generator and multiplier.
	logic [63:0] gen_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic        mix_sel_q;
	logic [15:0] draw_q;
	logic [15:0] a_q;

	// Delay path.
	logic signed [42:0] prod_q;
	logic [18:0]        xdiv_q;
	logic [DT_W-1:0]    dt_q;
	logic [31:0]        target_q;
	logic [31:0]        due_q;

	// Current item and scheduler state.
	logic [15:0] peer_q;
	logic [7:0]  chan_q;
	logic [15:0] handle_q;
	logic [31:0] tv_q;
	logic [31:0] cur_q;
	logic [31:0] ins_q;
	logic        placed_q;
	logic        dupd_q;
	logic [31:0] lost_q;
	logic [31:0] dupcnt_q;

	// Slot store.
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [31:0] slot_tick  [QUEUE_DEPTH];
	logic [31:0] slot_order [QUEUE_DEPTH];
	logic [15:0] slot_peer  [QUEUE_DEPTH];
	logic [7:0]  slot_chan  [QUEUE_DEPTH];
	logic [15:0] slot_handle[QUEUE_DEPTH];

	// Scan and pending release.
	logic [IDX_W-1:0] sidx_q;
	logic [IDX_W-1:0] best_q;
	logic [31:0]      best_tick_q;
	logic [31:0]      best_order_q;
	logic             found_q;
	logic [15:0]      pend_peer_q;
	logic [7:0]       pend_chan_q;
	logic [15:0]      pend_handle_q;
	logic [31:0]      pend_tick_q;

	// Output register.
	logic        ov_q;
	logic [1:0]  o_kind_q;
	logic        o_dup_q;
	logic [15:0] o_peer_q;
	logic [7:0]  o_chan_q;
	logic [15:0] o_handle_q;
	logic [31:0] o_due_q;
	logic        o_last_q;
	logic [31:0] o_lost_q;
	logic [31:0] o_dupcnt_q;

	// Combinational helpers.
	logic [63:0]        gen_next;
	logic [63:0]        mul_k;
	logic [63:0]        z_end;
	logic signed [17:0] sum_ab;
	logic signed [43:0] d_sum;
	logic [42:0]        d_pos;
	logic [44:0]        d_x3;
	logic [39:0]        div_prod;
	logic [15:0]        back;
	logic [IDX_W-1:0]   free_idx;
	logic               has_free;
	logic               cand;
	logic               better;

	assign gen_next = gen_q + GOLDEN;
	assign mul_k    = mix_sel_q ? MIX_C2 : MIX_C1;
	assign z_end    = acc_q ^ (acc_q >> 31);
	assign sum_ab   = $signed({2'b00, a_q}) + $signed({2'b00, draw_q}) - 18'sd65536;
	assign d_sum    = $signed({3'b000, mean_q, 17'd0}) + 44'(prod_q);
	assign d_pos    = d_sum[43] ? 43'd0 : d_sum[42:0];
	assign d_x3     = {1'b0, d_pos, 1'b0} + {2'b00, d_pos};
	assign div_prod = {21'd0, xdiv_q} * {19'd0, DIV_RECIP};
	assign back     = ({2'b00, dt_q} < window_q) ? {2'b00, dt_q} : window_q;

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		has_free = 1'b0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				has_free = 1'b1;
			end
		end
	end

	// Scan candidate: due, and earlier than the best so far, or as early and inserted before it.
	assign cand   = valid_q[sidx_q] && (slot_tick[sidx_q] <= tv_q);
	assign better = !found_q || (slot_tick[sidx_q] < best_tick_q) ||
		((slot_tick[sidx_q] == best_tick_q) && (slot_order[sidx_q] < best_order_q));

	// Status to the controller.
	always_comb begin
		status.out_free = !ov_q || m_axis_tready;
		status.lost_hit = {1'b0, draw_q} < loss_thr_q;
		status.pull_hit = draw_q < PULL_LIMIT;
		status.dup_hit  = {1'b0, draw_q} < dup_thr_q;
		status.placed   = placed_q;
		status.loss_nz  = loss_thr_q != '0;
		status.mean_nz  = mean_q != '0;
		status.win_nz   = window_q != '0;
		status.dup_nz   = dup_thr_q != '0;
		status.scan_end = sidx_q == IDX_W'(QUEUE_DEPTH - 1);
		status.found    = found_q;
	end

	// Configuration and generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q      <= '0;
			loss_thr_q <= '0;
			mean_q     <= '0;
			jitter_q   <= '0;
			window_q   <= '0;
			dup_thr_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEED:    gen_q      <= cfg_data;
					CFG_LOSS:    loss_thr_q <= cfg_data[16:0];
					CFG_MEAN:    mean_q     <= cfg_data[23:0];
					CFG_JITTER:  jitter_q   <= cfg_data[23:0];
					CFG_REORDER: window_q   <= cfg_data[15:0];
					CFG_DUP:     dup_thr_q  <= cfg_data[16:0];
					default: ;
				endcase
			end else if (cmd.op == OP_MIX_START) begin
				gen_q <= gen_next;
			end
		end
	end

	// Arithmetic registers: the 64-bit mixer runs on one 32x32 multiplier.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_MIX_START: begin
				x_q       <= gen_next ^ (gen_next >> 30);
				mix_sel_q <= 1'b0;
			end
			OP_MUL_P0: acc_q <= {32'd0, x_q[31:0]} * {32'd0, mul_k[31:0]};
			OP_MUL_P1: acc_q[63:32] <= acc_q[63:32] + 32'(x_q[31:0] * mul_k[63:32]);
			OP_MUL_P2: acc_q[63:32] <= acc_q[63:32] + 32'(x_q[63:32] * mul_k[31:0]);
			OP_MIX_MID: begin
				x_q       <= acc_q ^ (acc_q >> 27);
				mix_sel_q <= 1'b1;
			end
			OP_MIX_END:   draw_q <= z_end[63:48];
			OP_SAVE_A:    a_q    <= draw_q;
			OP_DELAY_MUL: prod_q <= 43'(sum_ab) * 43'($signed({1'b0, jitter_q}));
			OP_DELAY_SUM: xdiv_q <= d_x3[43:25];
			default: ;
		endcase
	end

	// Item capture, delay, enqueue bookkeeping and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			ins_q    <= '0;
			lost_q   <= '0;
			dupcnt_q <= '0;
			placed_q <= 1'b0;
			dupd_q   <= 1'b0;
			dt_q     <= '0;
		end else if (in_accept) begin
			placed_q <= 1'b0;
			dupd_q   <= 1'b0;
			dt_q     <= '0;
		end else begin
			case (cmd.op)
				OP_DELAY_DIV: dt_q <= div_prod[DIV_SHIFT + DT_W - 1:DIV_SHIFT];
				OP_ENQ_PRI: begin
					placed_q <= has_free;
					if (has_free) ins_q <= ins_q + 32'd1;
				end
				OP_ENQ_DUP: begin
					if (has_free) begin
						ins_q    <= ins_q + 32'd1;
						dupcnt_q <= dupcnt_q + 32'd1;
						dupd_q   <= 1'b1;
					end
				end
				OP_EMIT_LOST: lost_q <= lost_q + 32'd1;
				OP_TICK_SET:  cur_q  <= tv_q;
				default: ;
			endcase
		end
	end

	// Payload of the current item and its due ticks.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			peer_q   <= in_data[15:0];
			chan_q   <= in_data[23:16];
			handle_q <= in_data[39:24];
			tv_q     <= in_data[71:40];
		end
		case (cmd.op)
			OP_TARGET: begin
				target_q <= cur_q + 32'(dt_q);
				due_q    <= cur_q + 32'(dt_q);
			end
			OP_PULL: due_q <= (target_q > 32'(back)) ? target_q - 32'(back) : 32'd0;
			default: ;
		endcase
	end

	// Slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			case (cmd.op)
				OP_ENQ_PRI, OP_ENQ_DUP: if (has_free) valid_q[free_idx] <= 1'b1;
				OP_TAKE: valid_q[best_q] <= 1'b0;
				default: ;
			endcase
		end
	end

	// Slot contents.
	always_ff @(posedge clk) begin
		if ((cmd.op == OP_ENQ_PRI || cmd.op == OP_ENQ_DUP) && has_free) begin
			slot_tick[free_idx]   <= (cmd.op == OP_ENQ_PRI) ? due_q : target_q;
			slot_order[free_idx]  <= ins_q + 32'd1;
			slot_peer[free_idx]   <= peer_q;
			slot_chan[free_idx]   <= chan_q;
			slot_handle[free_idx] <= handle_q;
		end
	end

	// Scan for the earliest due slot, one slot a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_SCAN_INIT: begin
					sidx_q  <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN_STEP: begin
					sidx_q <= sidx_q + IDX_W'(1);
					if (cand && better) found_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Best slot and the release that waits to be sent.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_SCAN_STEP && cand && better) begin
			best_q       <= sidx_q;
			best_tick_q  <= slot_tick[sidx_q];
			best_order_q <= slot_order[sidx_q];
		end
		if (cmd.op == OP_TAKE) begin
			pend_peer_q   <= slot_peer[best_q];
			pend_chan_q   <= slot_chan[best_q];
			pend_handle_q <= slot_handle[best_q];
			pend_tick_q   <= best_tick_q;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.op == OP_EMIT_SEND || cmd.op == OP_EMIT_LOST ||
			cmd.op == OP_EMIT_REL) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_EMIT_SEND: begin
				o_kind_q   <= placed_q ? KIND_QUEUED : KIND_FULL;
				o_dup_q    <= dupd_q;
				o_peer_q   <= peer_q;
				o_chan_q   <= chan_q;
				o_handle_q <= handle_q;
				o_due_q    <= due_q;
				o_last_q   <= 1'b1;
				o_lost_q   <= lost_q;
				o_dupcnt_q <= dupcnt_q;
			end
			OP_EMIT_LOST: begin
				o_kind_q   <= KIND_LOST;
				o_dup_q    <= 1'b0;
				o_peer_q   <= peer_q;
				o_chan_q   <= chan_q;
				o_handle_q <= handle_q;
				o_due_q    <= '0;
				o_last_q   <= 1'b1;
				o_lost_q   <= lost_q + 32'd1;
				o_dupcnt_q <= dupcnt_q;
			end
			OP_EMIT_REL: begin
				o_kind_q   <= KIND_RELEASED;
				o_dup_q    <= 1'b0;
				o_peer_q   <= pend_peer_q;
				o_chan_q   <= pend_chan_q;
				o_handle_q <= pend_handle_q;
				o_due_q    <= pend_tick_q;
				o_last_q   <= cmd.last;
				o_lost_q   <= lost_q;
				o_dupcnt_q <= dupcnt_q;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser  = o_kind_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {7'd0, o_dupcnt_q, o_lost_q, o_due_q, o_handle_q,
		o_chan_q, o_peer_q, o_dup_q};

endmodule

### hdl/nlis_ctrl.sv
// Controller: sequences draws, delay arithmetic, enqueue and the release scans.
module nlis_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   in_mode,
	output logic                   s_axis_tready,
	output logic                   in_accept,
	input  nlis_pkg::nlis_status_t status,
	output nlis_pkg::nlis_cmd_t    cmd
);
	import nlis_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_LOSS, S_ADD, S_P0, S_P1, S_P2, S_MID, S_Q0, S_Q1, S_Q2, S_END,
		S_DEC, S_LAT, S_DMUL, S_DSUM, S_DDIV, S_TGT, S_REO, S_PULL, S_ENQ,
		S_DUPCHK, S_ENQD, S_SEND, S_LOST, S_TSET, S_SINIT, S_SCAN, S_SDONE,
		S_EPEND, S_TAKE, S_ELAST
	} state_t;

	typedef enum logic [2:0] {
		P_LOSS, P_LAT_A, P_LAT_B, P_REORD, P_DUP
	} purpose_t;

	state_t           state_q;
	purpose_t         purp_q;
	logic             pend_q;
	logic [CNT_W-1:0] cnt_q;

	assign s_axis_tready = state_q == S_IDLE;
	assign in_accept     = s_axis_tready && s_axis_tvalid;

	// Datapath command for the present state.
	always_comb begin
		cmd.op   = OP_NOP;
		cmd.last = 1'b0;
		case (state_q)
			S_ADD:  cmd.op = OP_MIX_START;
			S_P0:   cmd.op = OP_MUL_P0;
			S_P1:   cmd.op = OP_MUL_P1;
			S_P2:   cmd.op = OP_MUL_P2;
			S_MID:  cmd.op = OP_MIX_MID;
			S_Q0:   cmd.op = OP_MUL_P0;
			S_Q1:   cmd.op = OP_MUL_P1;
			S_Q2:   cmd.op = OP_MUL_P2;
			S_END:  cmd.op = OP_MIX_END;
			S_DEC:  cmd.op = (purp_q == P_LAT_A) ? OP_SAVE_A : OP_NOP;
			S_DMUL: cmd.op = OP_DELAY_MUL;
			S_DSUM: cmd.op = OP_DELAY_SUM;
			S_DDIV: cmd.op = OP_DELAY_DIV;
			S_TGT:  cmd.op = OP_TARGET;
			S_PULL: cmd.op = OP_PULL;
			S_ENQ:  cmd.op = OP_ENQ_PRI;
			S_ENQD: cmd.op = OP_ENQ_DUP;
			S_SEND: cmd.op = status.out_free ? OP_EMIT_SEND : OP_NOP;
			S_LOST: cmd.op = status.out_free ? OP_EMIT_LOST : OP_NOP;
			S_TSET: cmd.op = OP_TICK_SET;
			S_SINIT: cmd.op = OP_SCAN_INIT;
			S_SCAN: cmd.op = OP_SCAN_STEP;
			S_EPEND: cmd.op = status.out_free ? OP_EMIT_REL : OP_NOP;
			S_TAKE: cmd.op = OP_TAKE;
			S_ELAST: begin
				cmd.op   = status.out_free ? OP_EMIT_REL : OP_NOP;
				cmd.last = 1'b1;
			end
			default: ;
		endcase
	end

	// State sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			purp_q  <= P_LOSS;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_accept) state_q <= in_mode ? S_TSET : S_LOSS;
				S_LOSS: begin
					purp_q  <= P_LOSS;
					state_q <= status.loss_nz ? S_ADD : S_LAT;
				end
				S_ADD: state_q <= S_P0;
				S_P0:  state_q <= S_P1;
				S_P1:  state_q <= S_P2;
				S_P2:  state_q <= S_MID;
				S_MID: state_q <= S_Q0;
				S_Q0:  state_q <= S_Q1;
				S_Q1:  state_q <= S_Q2;
				S_Q2:  state_q <= S_END;
				S_END: state_q <= S_DEC;
				S_DEC: begin
					case (purp_q)
						P_LOSS:  state_q <= status.lost_hit ? S_LOST : S_LAT;
						P_LAT_A: begin
							purp_q  <= P_LAT_B;
							state_q <= S_ADD;
						end
						P_LAT_B: state_q <= S_DMUL;
						P_REORD: state_q <= status.pull_hit ? S_PULL : S_ENQ;
						P_DUP:   state_q <= (status.dup_hit && status.placed) ? S_ENQD : S_SEND;
						default: state_q <= S_IDLE;
					endcase
				end
				S_LAT: begin
					purp_q  <= P_LAT_A;
					state_q <= status.mean_nz ? S_ADD : S_TGT;
				end
				S_DMUL: state_q <= S_DSUM;
				S_DSUM: state_q <= S_DDIV;
				S_DDIV: state_q <= S_TGT;
				S_TGT:  state_q <= S_REO;
				S_REO: begin
					purp_q  <= P_REORD;
					state_q <= status.win_nz ? S_ADD : S_ENQ;
				end
				S_PULL: state_q <= S_ENQ;
				S_ENQ:  state_q <= S_DUPCHK;
				S_DUPCHK: begin
					purp_q  <= P_DUP;
					state_q <= status.dup_nz ? S_ADD : S_SEND;
				end
				S_ENQD: state_q <= S_SEND;
				S_SEND: if (status.out_free) state_q <= S_IDLE;
				S_LOST: if (status.out_free) state_q <= S_IDLE;
				S_TSET: begin
					pend_q  <= 1'b0;
					cnt_q   <= '0;
					state_q <= S_SINIT;
				end
				S_SINIT: state_q <= S_SCAN;
				S_SCAN:  if (status.scan_end) state_q <= S_SDONE;
				S_SDONE: begin
					if (status.found) state_q <= pend_q ? S_EPEND : S_TAKE;
					else              state_q <= pend_q ? S_ELAST : S_IDLE;
				end
				S_EPEND: if (status.out_free) state_q <= S_TAKE;
				S_TAKE: begin
					pend_q  <= 1'b1;
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= (cnt_q == CNT_W'(MAX_RELEASE - 1)) ? S_ELAST : S_SINIT;
				end
				S_ELAST: if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/nlis_checker.sv
// Port-level assertions for the link impairment scheduler, bound to the top level.
module nlis_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [nlis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]                      m_axis_tuser,
	input logic                            m_axis_tlast
);
	import nlis_pkg::*;

	// One item at a time: after an input transfer the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted back to back");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Send results are always the only result of their item.
	a_send_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_RELEASED) |-> m_axis_tlast)
		else $error("send result without last mark");

	// A lost packet carries no due tick and no duplicate.
	a_lost_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_LOST) |->
		(m_axis_tdata[72:41] == 32'd0) && !m_axis_tdata[0])
		else $error("lost result has due tick or duplicate");

endmodule

bind network_link_impairment_scheduler_core nlis_checker u_nlis_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

### tb/sv/testbench.sv
// Self-checking testbench of the link impairment scheduler core.
module testbench;
	import nlis_pkg::*;

	localparam int DEPTH        = 32;
	localparam int SETTLE_CYC   = 150;
	localparam int WATCHDOG_MAX = 20000;
	localparam int QUIET_FROM   = 2000;
	localparam int QUIET_TO     = 4500;
	localparam logic [63:0] TICK_DIV = 64'd33554432000;
	localparam logic MODE_SEND = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct {
		logic [1:0]  kind;
		logic        dup;
		logic [15:0] peer;
		logic [7:0]  chan;
		logic [15:0] handle;
		logic [31:0] due;
		logic        last;
		logic [31:0] lost_cnt;
		logic [31:0] dup_cnt;
	} result_t;

	typedef struct {
		bit          is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0] val;
		logic        mode;
		logic [15:0] peer;
		logic [7:0]  chan;
		logic [15:0] handle;
		logic [31:0] tick;
		bit          typed;
		logic [1:0]  kind;
		logic [31:0] due;
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	network_link_impairment_scheduler_core #(.QUEUE_DEPTH(DEPTH)) dut (.*);

	// Mirror of the block's settings and state.
	logic [63:0] gen_state;
	logic [16:0] loss_thr, dup_thr;
	logic [23:0] mean_lat, jitter_lat;
	logic [15:0] reorder_win;
	logic [31:0] cur_tick, ins_count, lost_sum, dup_sum;
	bit          q_valid[DEPTH];
	logic [31:0] q_tick[DEPTH], q_order[DEPTH];
	logic [15:0] q_peer[DEPTH], q_handle[DEPTH];
	logic [7:0]  q_chan[DEPTH];

	result_t pending_results[$];
	int      mismatches = 0;
	int      cycle_no = 0;
	int      idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit quiet();
		return cycle_no >= QUIET_FROM && cycle_no < QUIET_TO;
	endfunction

	// One splitmix64 step; only the top 16 bits are used.
	function automatic logic [15:0] splitmix_draw();
		logic [63:0] z;
		gen_state = gen_state + GOLDEN;
		z = gen_state;
		z = (z ^ (z >> 30)) * MIX_C1;
		z = (z ^ (z >> 27)) * MIX_C2;
		z = z ^ (z >> 31);
		return z[63:48];
	endfunction

	function automatic bit queue_insert(logic [31:0] t, logic [15:0] p, logic [7:0] c,
			logic [15:0] h);
		for (int i = 0; i < DEPTH; i++) begin
			if (!q_valid[i]) begin
				ins_count = ins_count + 1;
				q_valid[i] = 1'b1;
				q_tick[i] = t;
				q_order[i] = ins_count;
				q_peer[i] = p;
				q_chan[i] = c;
				q_handle[i] = h;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		case (idx)
			CFG_SEED: begin
				gen_state = v;
			end
			CFG_LOSS: loss_thr = v[16:0];
			CFG_MEAN: mean_lat = v[23:0];
			CFG_JITTER: jitter_lat = v[23:0];
			CFG_REORDER: reorder_win = v[15:0];
			CFG_DUP: dup_thr = v[16:0];
			default: ;
		endcase
	endfunction

	// Works out the results of one accepted item and queues them.
	function automatic void predict_impairment(logic mode, logic [15:0] p, logic [7:0] c,
			logic [15:0] h, logic [31:0] tv, bit typed, logic [1:0] tkind, logic [31:0] tdue);
		result_t r;
		logic [31:0] delay, target, due, back;
		longint a, b, d;
		bit pull, want_dup, placed;
		int n, best;
		result_t rel[$];
		r = '{default: '0};
		r.peer = p;
		r.chan = c;
		r.handle = h;
		r.last = 1'b1;
		if (mode == MODE_SEND) begin
			if (loss_thr != 0 && splitmix_draw() < loss_thr) begin
				lost_sum = lost_sum + 1;
				r.kind = KIND_LOST;
			end else begin
				delay = 0;
				if (mean_lat != 0) begin
					a = splitmix_draw();
					b = splitmix_draw();
					d = longint'(mean_lat) * 131072 + (a + b - 65536) * longint'(jitter_lat);
					if (d < 0)
						d = 0;
					delay = 32'((64'(d) * 64'd60) / TICK_DIV);
				end
				target = cur_tick + delay;
				due = target;
				pull = reorder_win != 0 && splitmix_draw() < PULL_LIMIT;
				if (pull) begin
					back = (32'(reorder_win) < delay) ? 32'(reorder_win) : delay;
					due = (target > back) ? target - back : 32'd0;
				end
				placed = queue_insert(due, p, c, h);
				want_dup = dup_thr != 0 && splitmix_draw() < dup_thr;
				r.due = due;
				if (!placed) begin
					r.kind = KIND_FULL;
				end else begin
					r.kind = KIND_QUEUED;
					if (want_dup && queue_insert(target, p, c, h)) begin
						r.dup = 1'b1;
						dup_sum = dup_sum + 1;
					end
				end
			end
			r.lost_cnt = lost_sum;
			r.dup_cnt = dup_sum;
			if (typed) begin
				r.kind = tkind;
				r.due = tdue;
			end
			pending_results.push_back(r);
		end else begin
			cur_tick = tv;
			n = 0;
			while (n < MAX_RELEASE) begin
				best = -1;
				for (int i = 0; i < DEPTH; i++) begin
					if (!q_valid[i] || q_tick[i] > tv)
						continue;
					if (best < 0 || q_tick[i] < q_tick[best] ||
							(q_tick[i] == q_tick[best] && q_order[i] < q_order[best]))
						best = i;
				end
				if (best < 0)
					break;
				q_valid[best] = 1'b0;
				r = '{default: '0};
				r.kind = KIND_RELEASED;
				r.peer = q_peer[best];
				r.chan = q_chan[best];
				r.handle = q_handle[best];
				r.due = q_tick[best];
				r.lost_cnt = lost_sum;
				r.dup_cnt = dup_sum;
				rel.push_back(r);
				n++;
			end
			if (n > 0)
				rel[n-1].last = 1'b1;
			foreach (rel[k])
				pending_results.push_back(rel[k]);
		end
	endfunction

	// Result side: random back-pressure and comparison against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.dup = m_axis_tdata[0];
				got.peer = m_axis_tdata[16:1];
				got.chan = m_axis_tdata[24:17];
				got.handle = m_axis_tdata[40:25];
				got.due = m_axis_tdata[72:41];
				got.lost_cnt = m_axis_tdata[104:73];
				got.dup_cnt = m_axis_tdata[136:105];
				got.last = m_axis_tlast;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got.kind !== want.kind || got.dup !== want.dup ||
							got.peer !== want.peer || got.chan !== want.chan ||
							got.handle !== want.handle || got.due !== want.due ||
							got.last !== want.last || got.lost_cnt !== want.lost_cnt ||
							got.dup_cnt !== want.dup_cnt) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			m_axis_tready <= quiet() || ($urandom_range(99) >= 9);
		end
	end

	// Cycle counter and stall watchdog.
	always @(posedge clk) begin
		cycle_no++;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("[network_link_impairment_scheduler_core] ERROR");
			$finish;
		end
	end

	// Waits for all results, then for the block to finish any item without results.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_cfg(idx, v);
	endtask

	// Offers one item and waits for its transfer.
	task automatic send_item(logic mode, logic [15:0] p, logic [7:0] c, logic [15:0] h,
			logic [31:0] tv, bit typed = 0, logic [1:0] tkind = KIND_QUEUED,
			logic [31:0] tdue = 0);
		if (!quiet() && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {tv, h, c, p};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_impairment(mode, p, c, h, tv, typed, tkind, tdue);
	endtask

	task automatic random_config(int phase);
		logic [63:0] v;
		drain_results();
		write_reg(CFG_SEED, {$urandom, $urandom});
		case ($urandom_range(3))
			0: v = 0;
			1: v = $urandom_range(20000);
			2: v = $urandom_range(65536);
			default: v = 0;
		endcase
		write_reg(CFG_LOSS, v);
		case ($urandom_range(3))
			0: v = 0;
			1: v = $urandom_range(24'h4000);
			2: v = $urandom_range(24'h40000);
			default: v = (phase == 3) ? 24'hFFFFFF : $urandom_range(24'h2000);
		endcase
		write_reg(CFG_MEAN, v);
		case ($urandom_range(3))
			0: v = 0;
			1: v = 24'hFFFFFF;
			default: v = $urandom_range(24'h40000);
		endcase
		write_reg(CFG_JITTER, v);
		case ($urandom_range(3))
			0: v = 0;
			1: v = 16'hFFFF;
			default: v = $urandom_range(1, 60);
		endcase
		write_reg(CFG_REORDER, v);
		case ($urandom_range(3))
			0: v = 0;
			1: v = 65536;
			default: v = $urandom_range(1, 65535);
		endcase
		write_reg(CFG_DUP, v);
	endtask

	initial begin
		row_t dir_rows[18];
		logic [31:0] tick_now;
		bit full_phase;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		gen_state = 0;
		loss_thr = 0;
		dup_thr = 0;
		mean_lat = 0;
		jitter_lat = 0;
		reorder_win = 0;
		cur_tick = 0;
		ins_count = 0;
		lost_sum = 0;
		dup_sum = 0;
		foreach (q_valid[i])
			q_valid[i] = 1'b0;

		// After reset every setting is zero: no draws, no delay.
		dir_rows = '{
			'{0, CFG_SEED, 0, MODE_SEND, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF,
				1, KIND_QUEUED, 0},
			'{0, CFG_SEED, 0, MODE_SEND, 0, 0, 0, 0, 1, KIND_QUEUED, 0},
			'{0, CFG_SEED, 0, MODE_TICK, 16'h1234, 8'h56, 16'h789A, 0, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_TICK, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_SEND, 16'hA5A5, 8'h5A, 16'h0F0F, 0,
				1, KIND_QUEUED, 32'hFFFFFFFF},
			// A decreasing tick is accepted and releases nothing here.
			'{0, CFG_SEED, 0, MODE_TICK, 0, 0, 0, 5, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_TICK, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0},
			'{1, CFG_SEED, 64'h0123456789ABCDEF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, CFG_LOSS, 65536, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_SEND, 16'h0001, 8'h02, 16'h0003, 0, 1, KIND_LOST, 0},
			'{1, CFG_LOSS, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, CFG_MEAN, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, CFG_JITTER, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, CFG_REORDER, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, CFG_DUP, 65536, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_SEND, 16'h00FF, 8'h80, 16'hFF00, 0, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_SEND, 16'h7FFF, 8'h01, 16'h8000, 0, 0, 0, 0},
			'{0, CFG_SEED, 0, MODE_TICK, 0, 0, 0, 32'd20000, 0, 0, 0}
		};

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain_results();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_item(dir_rows[i].mode, dir_rows[i].peer, dir_rows[i].chan,
					dir_rows[i].handle, dir_rows[i].tick, dir_rows[i].typed,
					dir_rows[i].kind, dir_rows[i].due);
			end
		end

		// Random phases, each under its own settings.
		tick_now = cur_tick;
		for (int ph = 0; ph < 8; ph++) begin
			random_config(ph);
			full_phase = (ph == 2 || ph == 6);
			for (int k = 0; k < 46; k++) begin
				if (k == 23 && ph == 4)
					drain_results();
				if ($urandom_range(99) < (full_phase ? 5 : 30)) begin
					case ($urandom_range(9))
						0: tick_now = tick_now - $urandom_range(20);
						1: tick_now = $urandom;
						2: tick_now = 32'hFFFFFFFF - $urandom_range(3);
						default: tick_now = tick_now + $urandom_range(150);
					endcase
					send_item(MODE_TICK, $urandom, $urandom, $urandom, tick_now);
				end else begin
					send_item(MODE_SEND, $urandom, $urandom, $urandom, $urandom);
				end
			end
			// Flush the queue now and then with a far tick.
			if (ph % 3 == 2) begin
				tick_now = 32'hFFFFFFFF;
				send_item(MODE_TICK, $urandom, $urandom, $urandom, tick_now);
				send_item(MODE_TICK, $urandom, $urandom, $urandom, tick_now);
				tick_now = $urandom_range(1000);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("[network_link_impairment_scheduler_core] OK");
		else
			$display("[network_link_impairment_scheduler_core] ERROR");
		$finish;
	end
endmodule
